/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/ibt_pkg.sv */
package ibt_pkg;

   // Input op codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;

   // Decoded command kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_SWEEP = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // Register indexes
   localparam logic CSR_SWEEP_INTERVAL = 1'b0;
   localparam logic CSR_EXPIRE_AFTER   = 1'b1;

   localparam logic [31:0] SWEEP_INTERVAL_RESET = 32'd10000;
   localparam logic [31:0] EXPIRE_AFTER_RESET   = 32'd3600000;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;
   localparam int CNT_FIELD_W = 7;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic [31:0] ip_address;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] stamp;
      logic [31:0] address;
   } entry_type;

   // Result word, lowest field last
   typedef struct packed {
      logic [6:0] entry_count;
      logic [6:0] removed_count;
      logic       sweep_ran;
      logic       table_full;
      logic       stored;
      logic       present;
   } rsp_type;

endpackage

/* rtl/ip_block_table_with_aging.sv */
// Blocked IPv4 address table with timed expiry.
// req_ channel: one word per operation (add, query or sweep) with the address
//   and the current millisecond time. rsp_ channel: exactly one word back per
//   request, in request order. csr_ port: write-only, takes effect at once;
//   write only while no request is in flight.
// Structure: a front slot decodes requests into a two-entry command queue; a
//   back engine walks the entry store one slot per cycle through its single
//   read port and holds the result in an output register.
// Flow: an accepted word waits in the front slot, then in the command queue;
//   the engine pops it, walks over the store, finishes and writes the result
//   register. A skipped sweep or an unused op goes from the pop straight to
//   the finish. The engine takes one command at a time; meanwhile the front
//   and the queue keep taking new words.
// Reset: synchronous. Afterwards the engine writes every slot invalid in turn;
//   req_tready stays low until that pass is done. Registers return to their
//   defaults.
// Stall: while rsp_tready is low the result word holds, the engine waits
//   with its next result, and the front keeps taking words until the queue
//   and its slot are full.
module ip_block_table_with_aging #(
   parameter int ENTRIES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // op[1:0], ip_address[33:2], now_ms[65:34], zero pad above
   input  logic [ibt_pkg::REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // present[0], stored[1], table_full[2], sweep_ran[3],
   // removed_count[10:4], entry_count[17:11], zero pad above
   output logic [ibt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [31:0]                    csr_wdata
);

   logic [31:0]         sweep_interval_ff, sweep_interval_in;
   logic [31:0]         expire_after_ff, expire_after_in;

   ibt_pkg::q_stat_type q_stat;
   ibt_pkg::cmd_type    push_cmd;
   ibt_pkg::cmd_type    head_cmd;
   ibt_pkg::rsp_type    rsp_word;
   logic                push;
   logic                pop;
   logic                clearing;

   // register file
   always_comb begin
      sweep_interval_in = sweep_interval_ff;
      expire_after_in   = expire_after_ff;
      if (csr_we) begin
         unique case (csr_index)
            ibt_pkg::CSR_SWEEP_INTERVAL: sweep_interval_in = csr_wdata;
            ibt_pkg::CSR_EXPIRE_AFTER:   expire_after_in   = csr_wdata;
            default:                     sweep_interval_in = sweep_interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_interval_ff <= ibt_pkg::SWEEP_INTERVAL_RESET;
         expire_after_ff   <= ibt_pkg::EXPIRE_AFTER_RESET;
      end else begin
         sweep_interval_ff <= sweep_interval_in;
         expire_after_ff   <= expire_after_in;
      end
   end

   ibt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clearing   (clearing),
      .q_stat     (q_stat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ibt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   ibt_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .sweep_interval_ms (sweep_interval_ff),
      .expire_after_ms   (expire_after_ff),
      .q_stat            (q_stat),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_word          (rsp_word)
   );

   // pad the 18-bit result word out to whole bytes
   assign rsp_tdata = {{(ibt_pkg::RSP_DATA_W - $bits(rsp_word)){1'b0}}, rsp_word};

endmodule

/* rtl/ibt_front.sv */
module ibt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ibt_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              clearing,
   input  ibt_pkg::q_stat_type               q_stat,
   output logic                              push,
   output ibt_pkg::cmd_type                  push_cmd
);

   logic             slot_vld_ff, slot_vld_in;
   ibt_pkg::cmd_type slot_cmd_ff, slot_cmd_in;
   logic             accept;
   logic [1:0]       kind;

   always_comb begin
      unique case (req_tdata[1:0])
         ibt_pkg::OP_ADD:   kind = ibt_pkg::KIND_ADD;
         ibt_pkg::OP_QUERY: kind = ibt_pkg::KIND_QUERY;
         ibt_pkg::OP_SWEEP: kind = ibt_pkg::KIND_SWEEP;
         default:           kind = ibt_pkg::KIND_NONE;
      endcase
   end

   assign push       = slot_vld_ff && !q_stat.full;
   assign req_tready = !clearing && (!slot_vld_ff || !q_stat.full);
   assign accept     = req_tvalid && req_tready;
   assign push_cmd   = slot_cmd_ff;

   always_comb begin
      slot_vld_in = slot_vld_ff;
      slot_cmd_in = slot_cmd_ff;
      if (accept) begin
         slot_vld_in            = 1'b1;
         slot_cmd_in.kind       = kind;
         slot_cmd_in.ip_address = req_tdata[33:2];
         slot_cmd_in.now_ms     = req_tdata[65:34];
      end else if (push) begin
         slot_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= 1'b0;
      end else begin
         slot_vld_ff <= slot_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_cmd_ff <= slot_cmd_in;
   end

endmodule

/* rtl/ibt_queue.sv */
module ibt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ibt_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output ibt_pkg::cmd_type     head_cmd,
   output ibt_pkg::q_stat_type  q_stat
);

   localparam int PW = (ibt_pkg::QUEUE_DEPTH > 1) ? $clog2(ibt_pkg::QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(ibt_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(ibt_pkg::QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(ibt_pkg::QUEUE_DEPTH);

   ibt_pkg::cmd_type slot_ff [ibt_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;

   assign q_stat.empty = (fill_ff == '0);
   assign q_stat.full  = (fill_ff == FULL_FILL);
   assign head_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + FW'(1);
         2'b01:   fill_in = fill_ff - FW'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/ibt_engine.sv */
module ibt_engine #(
   parameter int ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          sweep_interval_ms,
   input  logic [31:0]          expire_after_ms,
   input  ibt_pkg::q_stat_type  q_stat,
   input  ibt_pkg::cmd_type     head_cmd,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ibt_pkg::rsp_type     rsp_word
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   ibt_pkg::entry_type mem [ENTRIES];
   ibt_pkg::entry_type rd_data_ff;
   ibt_pkg::entry_type mem_wdata;
   logic [IW-1:0]      mem_waddr;
   logic               mem_we;
   logic               mem_re;

   logic [1:0]         state_ff, state_in;
   ibt_pkg::cmd_type   cmd_ff, cmd_in;
   logic               ran_ff, ran_in;
   logic               iss_ff, iss_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic               p_vld_ff, p_vld_in;
   logic [IW-1:0]      p_idx_ff, p_idx_in;
   logic               found_ff, found_in;
   logic               free_ok_ff, free_ok_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic [CW-1:0]      removed_ff, removed_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        last_sweep_ff, last_sweep_in;
   logic [IW-1:0]      clr_idx_ff, clr_idx_in;
   logic               out_vld_ff, out_vld_in;
   ibt_pkg::rsp_type   out_ff, out_in;

   logic [31:0]        since_sweep;
   logic [31:0]        age;
   logic               run_sweep;
   logic               do_store;
   logic               do_full;
   logic               is_lookup;
   logic               out_free;
   logic [CW-1:0]      count_next;

   assign since_sweep = head_cmd.now_ms - last_sweep_ff;
   assign run_sweep   = (head_cmd.kind == ibt_pkg::KIND_SWEEP) && (count_ff != '0)
                        && (since_sweep >= sweep_interval_ms);
   assign age         = cmd_ff.now_ms - rd_data_ff.stamp;
   assign is_lookup   = (cmd_ff.kind == ibt_pkg::KIND_ADD)
                        || (cmd_ff.kind == ibt_pkg::KIND_QUERY);
   assign do_store    = (cmd_ff.kind == ibt_pkg::KIND_ADD) && !found_ff && free_ok_ff;
   assign do_full     = (cmd_ff.kind == ibt_pkg::KIND_ADD) && !found_ff && !free_ok_ff;
   assign count_next  = count_ff - removed_ff + CW'(do_store);
   assign out_free    = !out_vld_ff || rsp_tready;

   assign pop        = (state_ff == ST_IDLE) && !q_stat.empty;
   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_word   = out_ff;
   assign mem_re     = (state_ff == ST_WALK) && iss_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ran_in        = ran_ff;
      iss_in        = iss_ff;
      rd_idx_in     = rd_idx_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = p_idx_ff;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      count_in      = count_ff;
      last_sweep_in = last_sweep_ff;
      clr_idx_in    = clr_idx_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_in        = out_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_idx_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // write every slot invalid once after reset
            mem_we     = 1'b1;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               cmd_in     = head_cmd;
               ran_in     = run_sweep;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               removed_in = '0;
               rd_idx_in  = '0;
               if (run_sweep) begin
                  last_sweep_in = head_cmd.now_ms;
               end
               if (run_sweep || (head_cmd.kind == ibt_pkg::KIND_ADD)
                   || (head_cmd.kind == ibt_pkg::KIND_QUERY)) begin
                  iss_in   = 1'b1;
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WALK: begin
            if (iss_ff) begin
               rd_idx_in = rd_idx_ff + IW'(1);
               p_vld_in  = 1'b1;
               p_idx_in  = rd_idx_ff;
               if (rd_idx_ff == LAST_IDX) begin
                  iss_in = 1'b0;
               end
            end
            if (p_vld_ff) begin
               if (is_lookup) begin
                  if (rd_data_ff.valid && (rd_data_ff.address == cmd_ff.ip_address)) begin
                     found_in = 1'b1;
                  end
                  if (!rd_data_ff.valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = p_idx_ff;
                  end
               end else if (rd_data_ff.valid && (age >= expire_after_ms)) begin
                  mem_we     = 1'b1;
                  mem_waddr  = p_idx_ff;
                  mem_wdata  = rd_data_ff;
                  mem_wdata.valid = 1'b0;
                  removed_in = removed_ff + CW'(1);
               end
               if (p_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (do_store) begin
                  mem_we            = 1'b1;
                  mem_waddr         = free_idx_ff;
                  mem_wdata.valid   = 1'b1;
                  mem_wdata.stamp   = cmd_ff.now_ms;
                  mem_wdata.address = cmd_ff.ip_address;
               end
               count_in             = count_next;
               out_vld_in           = 1'b1;
               out_in.present       = is_lookup && found_ff;
               out_in.stored        = do_store;
               out_in.table_full    = do_full;
               out_in.sweep_ran     = ran_ff;
               out_in.removed_count = 7'(removed_ff);
               out_in.entry_count   = 7'(count_next);
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         iss_ff        <= 1'b0;
         p_vld_ff      <= 1'b0;
         count_ff      <= '0;
         last_sweep_ff <= '0;
         clr_idx_ff    <= '0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         p_vld_ff      <= p_vld_in;
         count_ff      <= count_in;
         last_sweep_ff <= last_sweep_in;
         clr_idx_ff    <= clr_idx_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ran_ff      <= ran_in;
      rd_idx_ff   <= rd_idx_in;
      p_idx_ff    <= p_idx_in;
      found_ff    <= found_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      removed_ff  <= removed_in;
      out_ff      <= out_in;
   end

   // Entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

endmodule

/* rtl/ibt_checker.sv */
`include "assert_macros.svh"

module ibt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ibt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic req_take;
   logic bad_flags;

   assign req_take  = req_tvalid && req_tready;
   // stored excludes present and table_full; a removal implies the sweep ran
   assign bad_flags = (rsp_tdata[1] && (rsp_tdata[0] || rsp_tdata[2]))
                      || ((rsp_tdata[10:4] != 7'd0) && !rsp_tdata[3]);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_tvalid && !req_tready)
   `ASSERT_IMPLY(a_rsp_flags, clock, reset, rsp_tvalid, !bad_flags)
   // a word taken in reset's shadow cannot exist: the store is being cleared
   `ASSERT_IMPLY(a_no_take_after_reset, clock, reset, $past(reset), !req_take)

endmodule

bind ip_block_table_with_aging ibt_checker u_ibt_checker (.*);
